FILE: rtl/core/dds_pkg.sv
// package for the disk drive spin and seek state machine
// holds state and event codes, item and result structs and widths
// no dependencies
package dds_pkg;

    localparam int ModeW  = 3;
    localparam int TicksW = 16;
    localparam int OutDataW = 16;

    localparam logic [TicksW-1:0] SpinUpTicksRst = 16'd1000;

    // event codes as they arrive on the input tuser
    localparam logic [ModeW-1:0] MODE_TICK      = 3'd0;
    localparam logic [ModeW-1:0] MODE_UP        = 3'd1;
    localparam logic [ModeW-1:0] MODE_DOWN      = 3'd2;
    localparam logic [ModeW-1:0] MODE_SEEK      = 3'd3;
    localparam logic [ModeW-1:0] MODE_INIT_UP   = 3'd4;
    localparam logic [ModeW-1:0] MODE_INIT_DOWN = 3'd5;

    // bit positions of the result tdata
    localparam int OUT_STATE_LSB = 0;
    localparam int OUT_STATE_MSB = 2;
    localparam int OUT_VC        = 3;
    localparam int OUT_BH        = 4;
    localparam int OUT_HO        = 5;
    localparam int OUT_READY     = 6;
    localparam int OUT_LOAD      = 7;
    localparam int OUT_DRV_RDY   = 8;
    localparam int OUT_IGNORED   = 9;

    typedef enum logic [2:0] {
        ST_INITIAL    = 3'd0,
        ST_UNLOADED   = 3'd1,
        ST_SPIN_UP    = 3'd2,
        ST_LOCKED     = 3'd3,
        ST_SEEKING    = 3'd4,
        ST_SPIN_DOWN  = 3'd5
    } t_state;

    localparam logic [2:0] STATE_LOCKED_CODE    = 3'd3;
    localparam logic [2:0] STATE_SPIN_DOWN_CODE = 3'd5;

    typedef enum logic [2:0] {
        EV_TICK      = 3'd0,
        EV_UP        = 3'd1,
        EV_DOWN      = 3'd2,
        EV_SEEK      = 3'd3,
        EV_INIT_UP   = 3'd4,
        EV_INIT_DOWN = 3'd5,
        EV_ELAPSED   = 3'd6,
        EV_INVALID   = 3'd7
    } t_event;

    typedef struct packed {
        logic [ModeW-1:0]  mode;
        logic [TicksW-1:0] seek_ticks;
    } t_item;

    // packed with drive_state in the lowest bits
    typedef struct packed {
        logic       ignored;
        logic       drive_ready;
        logic       load_light;
        logic       ready_light;
        logic       heads_out;
        logic       brush_home;
        logic       volume_check;
        logic [2:0] drive_state;
    } t_result;

endpackage

FILE: rtl/core/dds_in_stage.sv
// input register stage of the spin and seek state machine
// holds one accepted transaction until the state logic takes it
// depends on dds_pkg
module dds_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  dds_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_valid,
    output dds_pkg::t_item o_item
);

    logic           r_valid;
    dds_pkg::t_item r_item;

    assign o_s_tready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: rtl/core/dds_fsm.sv
// spin and seek state machine with countdown timer and status flags
// updates state when the held transaction is taken, gives the result
// depends on dds_pkg
module dds_fsm (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [dds_pkg::TicksW-1:0]   i_cfg_wr_data,
    input  logic                         i_take,
    input  dds_pkg::t_item               i_item,
    output dds_pkg::t_result             o_result
);

    logic [dds_pkg::TicksW-1:0] r_spin_up_ticks;
    dds_pkg::t_state            r_state;
    dds_pkg::t_state            n_state;
    logic [dds_pkg::TicksW-1:0] r_remaining;
    logic [dds_pkg::TicksW-1:0] n_remaining;
    logic                       r_running;
    logic                       n_running;
    logic                       r_vc;
    logic                       n_vc;
    logic                       r_bh;
    logic                       n_bh;
    logic                       r_ho;
    logic                       n_ho;
    logic                       r_ready_lamp;
    logic                       n_ready_lamp;
    logic                       r_load_lamp;
    logic                       n_load_lamp;

    dds_pkg::t_event            ev;
    logic                       handled;
    logic                       start;
    logic [dds_pkg::TicksW-1:0] start_val;
    logic                       drive_ready;
    logic [dds_pkg::TicksW-1:0] half;

    assign half = {1'b0, r_spin_up_ticks[dds_pkg::TicksW-1:1]};

    // event decode, a tick that runs the timer out becomes elapsed
    always_comb begin
        case (i_item.mode)
            dds_pkg::MODE_TICK: begin
                ev = (r_running && r_remaining <= 16'd1) ? dds_pkg::EV_ELAPSED
                                                         : dds_pkg::EV_TICK;
            end
            dds_pkg::MODE_UP:        ev = dds_pkg::EV_UP;
            dds_pkg::MODE_DOWN:      ev = dds_pkg::EV_DOWN;
            dds_pkg::MODE_SEEK:      ev = dds_pkg::EV_SEEK;
            dds_pkg::MODE_INIT_UP:   ev = dds_pkg::EV_INIT_UP;
            dds_pkg::MODE_INIT_DOWN: ev = dds_pkg::EV_INIT_DOWN;
            default:                 ev = dds_pkg::EV_INVALID;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        handled = 1'b0;
        case (r_state)
            dds_pkg::ST_INITIAL: begin
                if (ev == dds_pkg::EV_INIT_UP) begin
                    n_state = dds_pkg::ST_LOCKED;
                    handled = 1'b1;
                end else if (ev == dds_pkg::EV_INIT_DOWN) begin
                    n_state = dds_pkg::ST_UNLOADED;
                    handled = 1'b1;
                end
            end
            dds_pkg::ST_UNLOADED: begin
                if (ev == dds_pkg::EV_UP) begin
                    n_state = dds_pkg::ST_SPIN_UP;
                    handled = 1'b1;
                end
            end
            dds_pkg::ST_SPIN_UP: begin
                if (ev == dds_pkg::EV_ELAPSED) begin
                    n_state = dds_pkg::ST_LOCKED;
                    handled = 1'b1;
                end else if (ev == dds_pkg::EV_DOWN) begin
                    n_state = dds_pkg::ST_SPIN_DOWN;
                    handled = 1'b1;
                end
            end
            dds_pkg::ST_LOCKED: begin
                if (ev == dds_pkg::EV_SEEK) begin
                    n_state = dds_pkg::ST_SEEKING;
                    handled = 1'b1;
                end else if (ev == dds_pkg::EV_DOWN) begin
                    n_state = dds_pkg::ST_SPIN_DOWN;
                    handled = 1'b1;
                end
            end
            dds_pkg::ST_SEEKING: begin
                if (ev == dds_pkg::EV_ELAPSED) begin
                    n_state = dds_pkg::ST_LOCKED;
                    handled = 1'b1;
                end else if (ev == dds_pkg::EV_DOWN) begin
                    n_state = dds_pkg::ST_SPIN_DOWN;
                    handled = 1'b1;
                end
            end
            dds_pkg::ST_SPIN_DOWN: begin
                if (ev == dds_pkg::EV_ELAPSED) begin
                    n_state = dds_pkg::ST_UNLOADED;
                    handled = 1'b1;
                end else if (ev == dds_pkg::EV_UP) begin
                    n_state = dds_pkg::ST_SPIN_UP;
                    handled = 1'b1;
                end
            end
            default: begin
                n_state = r_state;
                handled = 1'b0;
            end
        endcase
    end

    // flags, lamps and timer
    always_comb begin
        n_vc         = r_vc;
        n_bh         = r_bh;
        n_ho         = r_ho;
        n_ready_lamp = r_ready_lamp;
        n_load_lamp  = r_load_lamp;
        drive_ready  = 1'b0;
        start        = 1'b0;
        start_val    = r_spin_up_ticks;
        case (r_state)
            dds_pkg::ST_INITIAL: begin
                if (ev == dds_pkg::EV_INIT_UP) begin
                    n_load_lamp  = 1'b0;
                    n_ready_lamp = 1'b1;
                    n_vc         = 1'b1;
                    n_bh         = 1'b1;
                    n_ho         = 1'b1;
                    drive_ready  = 1'b1;
                end
            end
            dds_pkg::ST_UNLOADED: begin
                if (ev == dds_pkg::EV_UP) begin
                    n_load_lamp = 1'b0;
                    start       = 1'b1;
                    start_val   = r_spin_up_ticks;
                end
            end
            dds_pkg::ST_SPIN_UP: begin
                if (ev == dds_pkg::EV_ELAPSED) begin
                    n_ready_lamp = 1'b1;
                    n_vc         = 1'b1;
                    n_ho         = 1'b1;
                    drive_ready  = 1'b1;
                end else if (ev == dds_pkg::EV_DOWN) begin
                    n_ready_lamp = 1'b0;
                    n_ho         = 1'b0;
                    start        = 1'b1;
                    start_val    = half;
                end
            end
            dds_pkg::ST_LOCKED: begin
                if (ev == dds_pkg::EV_SEEK) begin
                    n_ready_lamp = 1'b0;
                    start        = 1'b1;
                    start_val    = i_item.seek_ticks;
                end else if (ev == dds_pkg::EV_DOWN) begin
                    n_ready_lamp = 1'b0;
                    n_ho         = 1'b0;
                    start        = 1'b1;
                    start_val    = r_spin_up_ticks;
                end
            end
            dds_pkg::ST_SEEKING: begin
                if (ev == dds_pkg::EV_ELAPSED) begin
                    n_ready_lamp = 1'b1;
                    drive_ready  = 1'b1;
                end else if (ev == dds_pkg::EV_DOWN) begin
                    n_ready_lamp = 1'b0;
                    n_ho         = 1'b0;
                    start        = 1'b1;
                    start_val    = half;
                end
            end
            dds_pkg::ST_SPIN_DOWN: begin
                if (ev == dds_pkg::EV_ELAPSED) begin
                    n_load_lamp = 1'b1;
                end else if (ev == dds_pkg::EV_UP) begin
                    start     = 1'b1;
                    start_val = half;
                end
            end
            default: begin
                drive_ready = 1'b0;
            end
        endcase

        n_remaining = r_remaining;
        n_running   = r_running;
        if (ev == dds_pkg::EV_ELAPSED) begin
            n_remaining = '0;
            n_running   = 1'b0;
        end else if (ev == dds_pkg::EV_TICK && r_running) begin
            n_remaining = r_remaining - 16'd1;
        end
        if (start) begin
            n_remaining = start_val;
            n_running   = 1'b1;
        end
    end

    always_comb begin
        o_result.drive_state  = n_state;
        o_result.volume_check = n_vc;
        o_result.brush_home   = n_bh;
        o_result.heads_out    = n_ho;
        o_result.ready_light  = n_ready_lamp;
        o_result.load_light   = n_load_lamp;
        o_result.drive_ready  = drive_ready;
        o_result.ignored      = (ev != dds_pkg::EV_TICK) && !handled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spin_up_ticks <= dds_pkg::SpinUpTicksRst;
        end else if (i_cfg_wr_en) begin
            r_spin_up_ticks <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= dds_pkg::ST_INITIAL;
            r_remaining  <= '0;
            r_running    <= 1'b0;
            r_vc         <= 1'b0;
            r_bh         <= 1'b0;
            r_ho         <= 1'b0;
            r_ready_lamp <= 1'b0;
            r_load_lamp  <= 1'b0;
        end else if (i_take) begin
            r_state      <= n_state;
            r_remaining  <= n_remaining;
            r_running    <= n_running;
            r_vc         <= n_vc;
            r_bh         <= n_bh;
            r_ho         <= n_ho;
            r_ready_lamp <= n_ready_lamp;
            r_load_lamp  <= n_load_lamp;
        end
    end

endmodule

FILE: rtl/core/dds_out_stage.sv
// result register stage of the spin and seek state machine
// decides when the held transaction advances and holds the result
// depends on dds_pkg
module dds_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  dds_pkg::t_result i_result,
    output logic             o_take,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output dds_pkg::t_result o_result
);

    logic             r_valid;
    dds_pkg::t_result r_result;

    assign o_take     = i_valid && (!r_valid || i_m_tready);
    assign o_m_tvalid = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: rtl/core/disk_drive_spin_seek_fsm.sv
// top level of the cartridge disk drive spin and seek state machine
// input stage, state machine and result stage; depends on dds_pkg
//
// usage
//   slave stream: tuser carries the event code, tdata the seek duration
//   in ticks. every accepted transaction gives exactly one result
//   transaction on the master stream with state, flags and lamps.
//   the spin time register is written through i_cfg_wr_en and
//   i_cfg_wr_data while no transaction is in flight.
// throughput
//   one transaction per cycle is sustained while the receiver keeps tready high;
//   the state update sits in a single pass between the input register and the
//   result register.
// reset
//   synchronous active-low reset empties both stages, returns the machine
//   to initial with timer stopped, flags and lamps off, and loads 1000
//   into the spin time register.
// stall
//   when the receiver holds tready low the result holds and the input
//   register fills, after which the slave tready drops.
module disk_drive_spin_seek_fsm (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // seek_ticks[15:0]
    input  logic [2:0]  s_axis_tuser,   // mode[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // drive_state[2:0], volume_check[3], brush_home[4], heads_out[5],
    // ready_light[6], load_light[7], drive_ready[8], ignored[9], zero[15:10]
    output logic [15:0] m_axis_tdata,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    dds_pkg::t_item   in_item;
    dds_pkg::t_item   held_item;
    dds_pkg::t_result fsm_result;
    dds_pkg::t_result out_result;
    logic             held_valid;
    logic             take;

    assign in_item.mode       = s_axis_tuser;
    assign in_item.seek_ticks = s_axis_tdata;

    dds_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_item     (in_item),
        .i_take     (take),
        .o_valid    (held_valid),
        .o_item     (held_item)
    );

    dds_fsm u_fsm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_take        (take),
        .i_item        (held_item),
        .o_result      (fsm_result)
    );

    dds_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (held_valid),
        .i_result   (fsm_result),
        .o_take     (take),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_result   (out_result)
    );

    assign m_axis_tdata = {{(dds_pkg::OutDataW - $bits(dds_pkg::t_result)){1'b0}}, out_result};

endmodule

FILE: rtl/core/dds_checker.sv
// port checker for the spin and seek state machine, bound to the top level
// watches result transactions and reset; depends on dds_pkg
module dds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_ready_lamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[dds_pkg::OUT_DRV_RDY]
        |-> m_axis_tdata[dds_pkg::OUT_READY] && !m_axis_tdata[dds_pkg::OUT_IGNORED])
        else $error("drive ready without ready lamp or with ignored");

    a_locked_lamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[dds_pkg::OUT_STATE_MSB:dds_pkg::OUT_STATE_LSB]
            == dds_pkg::STATE_LOCKED_CODE
        |-> m_axis_tdata[dds_pkg::OUT_READY])
        else $error("locked on with ready lamp off");

    a_spin_down_heads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[dds_pkg::OUT_STATE_MSB:dds_pkg::OUT_STATE_LSB]
            == dds_pkg::STATE_SPIN_DOWN_CODE
        |-> !m_axis_tdata[dds_pkg::OUT_HO] && !m_axis_tdata[dds_pkg::OUT_READY])
        else $error("spinning down with heads out or ready lamp on");

endmodule

bind disk_drive_spin_seek_fsm dds_checker u_dds_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
